// File: rtl/core/red_pkg.sv
// shared types and constants for the rounded euclidean distance core
`default_nettype none

package red_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } red_qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/red_front.sv
// front end: accepts point pairs and forms absolute coordinate differences
`default_nettype none

module red_front
    import red_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COORD_BITS-1:0] x_a,
    input  wire logic [COORD_BITS-1:0] y_a,
    input  wire logic [COORD_BITS-1:0] x_b,
    input  wire logic [COORD_BITS-1:0] y_b,
    input  wire red_qstat_t            qstat,
    output logic                       push,
    output logic [COORD_BITS-1:0]      dx,
    output logic [COORD_BITS-1:0]      dy
);

    logic [COORD_BITS:0] diff_x;
    logic [COORD_BITS:0] diff_y;
    logic [COORD_BITS:0] neg_x;
    logic [COORD_BITS:0] neg_y;

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    // sign-extended differences
    assign diff_x = {x_a[COORD_BITS-1], x_a} - {x_b[COORD_BITS-1], x_b};
    assign diff_y = {y_a[COORD_BITS-1], y_a} - {y_b[COORD_BITS-1], y_b};
    assign neg_x  = '0 - diff_x;
    assign neg_y  = '0 - diff_y;

    assign dx = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    assign dy = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/red_queue.sv
// short queue of coordinate differences between front and back
`default_nettype none

module red_queue
    import red_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 pop,
    output logic [DATA_BITS-1:0]      rd_data,
    output red_qstat_t                qstat
);

    logic [DATA_BITS-1:0] entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign qstat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign rd_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_BITS'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full) && !(pop && qstat.empty))
        else $error("queue push when full or pop when empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == QCNT_BITS'($past(count_reg) + 1'b1)))
        else $error("queue count lost a transfer");

endmodule

`default_nettype wire

// File: rtl/core/red_back.sv
// back end: squares, sums, pipelined integer square root and rounding
`default_nettype none

module red_back
    import red_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire red_qstat_t              qstat,
    input  wire logic [2*COORD_BITS-1:0] q_data,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [COORD_BITS:0]          distance
);

    localparam int C    = COORD_BITS;
    localparam int RADW = 2 * C + 2;
    localparam int RW   = C + 4;

    logic adv;

    logic              sq_vld_reg;
    logic [2*C-1:0]    dx2_reg;
    logic [2*C-1:0]    dy2_reg;
    logic              sum_vld_reg;
    logic [RADW-1:0]   sum_reg;

    logic              st_vld_reg  [0:C];
    logic [RW-1:0]     st_rem_reg  [0:C];
    logic [C:0]        st_root_reg [0:C];
    logic [RADW-1:0]   st_rad_reg  [0:C];

    logic              st_vld_next  [0:C];
    logic [RW-1:0]     st_rem_next  [0:C];
    logic [C:0]        st_root_next [0:C];

    logic              out_vld_reg;
    logic [C:0]        dist_reg;
    logic [C:0]        dist_next;

    assign adv       = !out_vld_reg || !out_stall;
    assign pop       = adv && !qstat.empty;
    assign out_valid = out_vld_reg;
    assign distance  = dist_reg;

    // one root bit per stage, most significant first
    for (genvar k = 0; k <= C; k++)
    begin : g_sqrt
        localparam int PI = C - k;
        logic [RW-1:0]   rem_in;
        logic [C:0]      root_in;
        logic [RADW-1:0] rad_in;
        logic            vld_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;
        logic            take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = sum_reg;
            assign vld_in  = sum_vld_reg;
        end
        else
        begin : g_rest
            assign rem_in  = st_rem_reg[k-1];
            assign root_in = st_root_reg[k-1];
            assign rad_in  = st_rad_reg[k-1];
            assign vld_in  = st_vld_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], rad_in[2*PI+1 -: 2]};
        assign trial  = RW'({root_in, 2'b01});
        assign take   = (rem_sh >= trial);

        always_comb
        begin
            st_vld_next[k]  = vld_in;
            st_rem_next[k]  = take ? RW'(rem_sh - trial) : rem_sh;
            st_root_next[k] = {root_in[C-1:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                st_vld_reg[k] <= st_vld_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_rem_reg[k]  <= st_rem_next[k];
                st_root_reg[k] <= st_root_next[k];
                st_rad_reg[k]  <= rad_in;
            end
        end
    end

    // round up when the remainder exceeds the root
    always_comb
    begin
        if (st_rem_reg[C] > RW'(st_root_reg[C]))
        begin
            dist_next = (C + 1)'(st_root_reg[C] + 1'b1);
        end
        else
        begin
            dist_next = st_root_reg[C];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg  <= pop;
            sum_vld_reg <= sq_vld_reg;
            out_vld_reg <= st_vld_reg[C];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx2_reg  <= q_data[2*C-1:C] * q_data[2*C-1:C];
            dy2_reg  <= q_data[C-1:0] * q_data[C-1:0];
            sum_reg  <= RADW'(dx2_reg) + RADW'(dy2_reg);
            dist_reg <= dist_next;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> ($stable(st_vld_reg[C]) && $stable(sum_vld_reg)))
        else $error("pipeline moved while output stalled");

    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sq_vld_reg)
        else $error("popped item lost");

endmodule

`default_nettype wire

// File: rtl/core/rounded_euclidean_distance_core.sv
// top level of the rounded euclidean distance core
//
// usage:
//   input channel: in_valid / in_stall with x_a, y_a, x_b, y_b (signed)
//   output channel: out_valid / out_stall with distance (unsigned)
//   a transfer happens on a rising edge with valid high and stall low
//   each input transfer yields one distance, the integer square root of
//   dx*dx + dy*dy rounded to nearest, in input order
// path: from input to output transfer a pair passes the queue, square, sum,
//   COORD_BITS + 1 square root stages, rounding into the output register
// throughput: one pair per cycle while out_stall does not hold the output;
//   the square root pipeline retires one root bit per stage
// reset: clears the queue and all valid flags, no result pending
// receiver stall: the back pipeline holds, the four-entry queue keeps
//   taking pairs until full, then in_stall rises
`default_nettype none

module rounded_euclidean_distance_core
    import red_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COORD_BITS-1:0] x_a,
    input  wire logic [COORD_BITS-1:0] y_a,
    input  wire logic [COORD_BITS-1:0] x_b,
    input  wire logic [COORD_BITS-1:0] y_b,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COORD_BITS:0]        distance
);

    red_qstat_t              qstat;
    logic                    push;
    logic                    pop;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] q_data;

    red_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .x_a      (x_a),
        .y_a      (y_a),
        .x_b      (x_b),
        .y_b      (y_b),
        .qstat    (qstat),
        .push     (push),
        .dx       (dx),
        .dy       (dy)
    );

    red_queue #(
        .DATA_BITS (2 * COORD_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({dx, dy}),
        .pop     (pop),
        .rd_data (q_data),
        .qstat   (qstat)
    );

    red_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance)
    );

endmodule

`default_nettype wire
